/* hdl/rth_pkg.sv */
package rth_pkg;

  localparam int unsigned CoordWidthDef = 16;
  localparam int unsigned CoordFracDef  = 8;
  localparam int unsigned EpsWidth      = 32;
  localparam int unsigned EpsFrac       = 24;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CfgDataWidth  = 32;

  typedef enum logic [2:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5,
    REG_EPS   = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    RSN_HIT      = 3'd0,
    RSN_PARALLEL = 3'd1,
    RSN_U_OUT    = 3'd2,
    RSN_V_OUT    = 3'd3,
    RSN_BEHIND   = 3'd4
  } miss_reason_e;

endpackage

/* hdl/ray_triangle_hit_test_top.sv */
// Ray / triangle hit test. One ray (origin and direction, written through the configuration
// port) is tested against a stream of triangles with the Moller-Trumbore method, without any
// division: the unscaled barycentrics are compared against the determinant, with the sense of
// each comparison flipped when the determinant is negative. A request is taken at every clock
// edge where start_i is high and busy_o is low; busy_o is always low, so one triangle enters in
// every cycle. The result appears on hit_o and miss_reason_o after the five register stages
// (edge subtraction, cross products, dot-product terms, their sums, and the final compares),
// marked by done_o for one cycle, in request order. The receiver cannot stall the block and
// none is needed: the pipeline never holds. Configuration must be written only while no
// request is in flight.
module ray_triangle_hit_test_top import rth_pkg::*; #(
  parameter int unsigned COORD_WIDTH     = CoordWidthDef,
  parameter int unsigned COORD_FRAC_BITS = CoordFracDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic signed [COORD_WIDTH-1:0]  vert_a_x_i,
  input  logic signed [COORD_WIDTH-1:0]  vert_a_y_i,
  input  logic signed [COORD_WIDTH-1:0]  vert_a_z_i,
  input  logic signed [COORD_WIDTH-1:0]  vert_b_x_i,
  input  logic signed [COORD_WIDTH-1:0]  vert_b_y_i,
  input  logic signed [COORD_WIDTH-1:0]  vert_b_z_i,
  input  logic signed [COORD_WIDTH-1:0]  vert_c_x_i,
  input  logic signed [COORD_WIDTH-1:0]  vert_c_y_i,
  input  logic signed [COORD_WIDTH-1:0]  vert_c_z_i,
  input  logic                           cfg_we_i,
  input  logic [CfgIdxWidth-1:0]         cfg_idx_i,
  input  logic [CfgDataWidth-1:0]        cfg_data_i,
  output logic                           done_o,
  output logic                           hit_o,
  output logic [2:0]                     miss_reason_o
);

  // Edges carry one extra bit, cross products are twice that plus one, dot terms add the
  // edge width again, and sums of three terms two more bits.
  localparam int unsigned EW = COORD_WIDTH + 1;
  localparam int unsigned CW = 2 * EW + 1;
  localparam int unsigned TW = CW + EW;
  localparam int unsigned DW = TW + 2;
  localparam int unsigned FR = 3 * COORD_FRAC_BITS;
  localparam int unsigned SH_EPS = (FR >= EpsFrac) ? FR - EpsFrac : 0;
  localparam int unsigned SH_MAG = (FR >= EpsFrac) ? 0 : EpsFrac - FR;
  localparam int unsigned MW = DW + SH_MAG + EpsWidth + SH_EPS + 1;

  typedef logic signed [EW-1:0] edge_t;
  typedef logic signed [CW-1:0] crs_t;
  typedef logic signed [TW-1:0] term_t;
  typedef logic signed [DW-1:0] dot_t;

  // Configuration registers.
  logic signed [COORD_WIDTH-1:0] org_q [3];
  logic signed [COORD_WIDTH-1:0] dir_q [3];
  logic [EpsWidth-1:0]           eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= '0;
      dir_q[1] <= '0;
      dir_q[2] <= COORD_WIDTH'(1 << COORD_FRAC_BITS);
      eps_q    <= EpsWidth'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ORG_X: org_q[0] <= cfg_data_i[COORD_WIDTH-1:0];
        REG_ORG_Y: org_q[1] <= cfg_data_i[COORD_WIDTH-1:0];
        REG_ORG_Z: org_q[2] <= cfg_data_i[COORD_WIDTH-1:0];
        REG_DIR_X: dir_q[0] <= cfg_data_i[COORD_WIDTH-1:0];
        REG_DIR_Y: dir_q[1] <= cfg_data_i[COORD_WIDTH-1:0];
        REG_DIR_Z: dir_q[2] <= cfg_data_i[COORD_WIDTH-1:0];
        REG_EPS:   eps_q    <= cfg_data_i[EpsWidth-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic acc;
  assign acc = start_i;

  // Valid bits, one per stage.
  logic [4:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], acc};
    end
  end

  // Stage 1: edges and origin offset.
  edge_t e1_q [3], e2_q [3], s_q [3];
  always_ff @(posedge clk_i) begin
    e1_q[0] <= EW'(vert_a_x_i) - EW'(vert_b_x_i);
    e1_q[1] <= EW'(vert_a_y_i) - EW'(vert_b_y_i);
    e1_q[2] <= EW'(vert_a_z_i) - EW'(vert_b_z_i);
    e2_q[0] <= EW'(vert_c_x_i) - EW'(vert_b_x_i);
    e2_q[1] <= EW'(vert_c_y_i) - EW'(vert_b_y_i);
    e2_q[2] <= EW'(vert_c_z_i) - EW'(vert_b_z_i);
    s_q[0]  <= EW'(org_q[0]) - EW'(vert_b_x_i);
    s_q[1]  <= EW'(org_q[1]) - EW'(vert_b_y_i);
    s_q[2]  <= EW'(org_q[2]) - EW'(vert_b_z_i);
  end

  // Stage 2: p = dir x e2 and q = s x e1.
  edge_t dv [3];
  assign dv[0] = EW'(dir_q[0]);
  assign dv[1] = EW'(dir_q[1]);
  assign dv[2] = EW'(dir_q[2]);

  crs_t p_q [3], q_q [3];
  edge_t e1_2q [3], e2_2q [3], s_2q [3];
  always_ff @(posedge clk_i) begin
    p_q[0] <= CW'(dv[1] * e2_q[2]) - CW'(dv[2] * e2_q[1]);
    p_q[1] <= CW'(dv[2] * e2_q[0]) - CW'(dv[0] * e2_q[2]);
    p_q[2] <= CW'(dv[0] * e2_q[1]) - CW'(dv[1] * e2_q[0]);
    q_q[0] <= CW'(s_q[1] * e1_q[2]) - CW'(s_q[2] * e1_q[1]);
    q_q[1] <= CW'(s_q[2] * e1_q[0]) - CW'(s_q[0] * e1_q[2]);
    q_q[2] <= CW'(s_q[0] * e1_q[1]) - CW'(s_q[1] * e1_q[0]);
    e1_2q  <= e1_q;
    e2_2q  <= e2_q;
    s_2q   <= s_q;
  end

  // Stage 3: products of the four dot products.
  term_t det_t_q [3], u_t_q [3], v_t_q [3], t_t_q [3];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      det_t_q[i] <= TW'(e1_2q[i] * p_q[i]);
      u_t_q[i]   <= TW'(s_2q[i] * p_q[i]);
      v_t_q[i]   <= TW'(dv[i] * q_q[i]);
      t_t_q[i]   <= TW'(e2_2q[i] * q_q[i]);
    end
  end

  // Stage 4: sums.
  dot_t det_q, un_q, vn_q, tn_q;
  always_ff @(posedge clk_i) begin
    det_q <= DW'(det_t_q[0]) + DW'(det_t_q[1]) + DW'(det_t_q[2]);
    un_q  <= DW'(u_t_q[0]) + DW'(u_t_q[1]) + DW'(u_t_q[2]);
    vn_q  <= DW'(v_t_q[0]) + DW'(v_t_q[1]) + DW'(v_t_q[2]);
    tn_q  <= DW'(t_t_q[0]) + DW'(t_t_q[1]) + DW'(t_t_q[2]);
  end

  // Stage 5: sign fold and classification. Values are widened by two bits so that
  // negating and summing cannot overflow.
  logic flip;
  logic signed [DW+1:0] det_f, un_f, vn_f, tn_f;
  logic [MW-1:0] mag_al, eps_al;
  logic [2:0] rsn_d;
  assign flip = det_q[DW-1];
  always_comb begin
    det_f  = flip ? -(DW+2)'(det_q) : (DW+2)'(det_q);
    un_f   = flip ? -(DW+2)'(un_q)  : (DW+2)'(un_q);
    vn_f   = flip ? -(DW+2)'(vn_q)  : (DW+2)'(vn_q);
    tn_f   = flip ? -(DW+2)'(tn_q)  : (DW+2)'(tn_q);
    mag_al = MW'(det_f) << SH_MAG;
    eps_al = MW'(eps_q) << SH_EPS;
    if (det_q == '0 || mag_al < eps_al) begin
      rsn_d = RSN_PARALLEL;
    end else if (un_f < 0 || det_f < un_f) begin
      rsn_d = RSN_U_OUT;
    end else if (vn_f < 0 || det_f < un_f + vn_f) begin
      rsn_d = RSN_V_OUT;
    end else if (tn_f < 0) begin
      rsn_d = RSN_BEHIND;
    end else begin
      rsn_d = RSN_HIT;
    end
  end

  logic [2:0] rsn_q;
  always_ff @(posedge clk_i) begin
    rsn_q <= rsn_d;
  end

  assign done_o        = vld_q[4];
  assign miss_reason_o = rsn_q;
  assign hit_o         = (rsn_q == RSN_HIT);

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##5 done_o)
    else $error("result strobe missing five cycles after request");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 5))
    else $error("result strobe without request");
  a_hit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hit_o == (miss_reason_o == RSN_HIT)))
    else $error("hit flag disagrees with reason");
`endif

endmodule

/* dv/tb_ray_triangle_hit_test_top.sv */
`timescale 1ns / 100ps

// Self-checking bench for the ray / triangle hit test. A directed table of triangles covers the
// parallel, barycentric and behind-origin cases plus coordinate extremes, then random triangles
// are streamed under several ray settings. Every request is classified by an exact predictor
// written here, and each strobed result is matched against the oldest expected outcome.
module tb_ray_triangle_hit_test_top;
  import rth_pkg::*;

  localparam int unsigned CW = CoordWidthDef;
  localparam int unsigned CF = CoordFracDef;
  localparam int unsigned PIPE_DEPTH = 5;
  localparam int unsigned RANDOM_TRIS = 1500;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [127:0] wide_t;

  // One triangle request. The vertices are held as an unpacked array a.x .. c.z.
  typedef struct {
    coord_t v[9];
  } tri_req_t;

  // One outcome: the expected hit flag and miss reason.
  typedef struct {
    logic         hit;
    miss_reason_e reason;
  } outcome_t;

  // A directed row: a triangle plus an optional typed-in outcome.
  typedef struct {
    tri_req_t     tri_in;
    logic         fixed;
    miss_reason_e reason;
  } tri_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  coord_t vert_i[9] = '{default: '0};
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;
  logic done_o;
  logic hit_o;
  logic [2:0] miss_reason_o;

  // Copy of the ray registers that the predictor uses.
  coord_t ray_org[3];
  coord_t ray_dir[3];
  logic [EpsWidth-1:0] ray_eps;

  outcome_t pending_outcomes[$];
  int unsigned mismatch_count = 0;
  int unsigned checked_count = 0;
  int unsigned hit_count = 0;
  int unsigned cycle_count = 0;
  int unsigned reason_seen[5];

  always #5 clk_i = ~clk_i;

  ray_triangle_hit_test_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .vert_a_x_i    (vert_i[0]),
    .vert_a_y_i    (vert_i[1]),
    .vert_a_z_i    (vert_i[2]),
    .vert_b_x_i    (vert_i[3]),
    .vert_b_y_i    (vert_i[4]),
    .vert_b_z_i    (vert_i[5]),
    .vert_c_x_i    (vert_i[6]),
    .vert_c_y_i    (vert_i[7]),
    .vert_c_z_i    (vert_i[8]),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .miss_reason_o (miss_reason_o)
  );

  // Exact Moller-Trumbore classification. Everything is carried in 128-bit signed integers,
  // which cannot overflow at these widths, so no rounding enters anywhere.
  function automatic miss_reason_e classify_triangle(tri_req_t t);
    wide_t a[3], b[3], c[3], e1[3], e2[3], p[3], s[3], q[3], d[3];
    wide_t det, mag, eps, un, vn, tn;
    logic flip;
    for (int k = 0; k < 3; k++) begin
      a[k] = wide_t'(t.v[k]);
      b[k] = wide_t'(t.v[3+k]);
      c[k] = wide_t'(t.v[6+k]);
      d[k] = wide_t'(ray_dir[k]);
      e1[k] = a[k] - b[k];
      e2[k] = c[k] - b[k];
      s[k] = wide_t'(ray_org[k]) - b[k];
    end
    p[0] = d[1] * e2[2] - d[2] * e2[1];
    p[1] = d[2] * e2[0] - d[0] * e2[2];
    p[2] = d[0] * e2[1] - d[1] * e2[0];
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    flip = det < 0;
    mag = flip ? -det : det;
    eps = wide_t'({96'd0, ray_eps});
    // The epsilon has 24 fraction bits; align whichever side has fewer.
    if (3 * CF >= EpsFrac) eps = eps <<< (3 * CF - EpsFrac);
    else mag = mag <<< (EpsFrac - 3 * CF);
    if (det == 0 || mag < eps) return RSN_PARALLEL;
    if (flip) det = -det;
    un = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
    if (flip) un = -un;
    if (un < 0 || det < un) return RSN_U_OUT;
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    vn = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    if (flip) vn = -vn;
    if (vn < 0 || det < un + vn) return RSN_V_OUT;
    tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (flip) tn = -tn;
    if (tn < 0) return RSN_BEHIND;
    return RSN_HIT;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Result checker: the block strobes done_o for one cycle and the bench cannot hold it off.
  always @(posedge clk_i) begin
    outcome_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result, reason", miss_reason_o, 0);
      end else begin
        want = pending_outcomes.pop_front();
        checked_count++;
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (miss_reason_o !== want.reason) report_mismatch("miss_reason", miss_reason_o, want.reason);
        if (want.hit) hit_count++;
        reason_seen[want.reason]++;
      end
    end
  end

  // Watchdog in case the block stops producing results.
  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drives one register write for a cycle; the caller drops the write enable after the last.
  task automatic write_reg(cfg_reg_e idx, logic [CfgDataWidth-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_ORG_X, REG_ORG_Y, REG_ORG_Z: ray_org[idx - REG_ORG_X] = coord_t'(data);
      REG_DIR_X, REG_DIR_Y, REG_DIR_Z: ray_dir[idx - REG_DIR_X] = coord_t'(data);
      REG_EPS: ray_eps = data;
      default: ;
    endcase
  endtask

  // Loads a whole ray; the upper data bits carry junk that the block must mask off.
  task automatic load_ray(coord_t ox, coord_t oy, coord_t oz, coord_t dx, coord_t dy,
                          coord_t dz, logic [31:0] eps);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(REG_ORG_X, {junk, ox});
    write_reg(REG_ORG_Y, {~junk, oy});
    write_reg(REG_ORG_Z, {junk, oz});
    write_reg(REG_DIR_X, {~junk, dx});
    write_reg(REG_DIR_Y, {junk, dy});
    write_reg(REG_DIR_Z, {~junk, dz});
    write_reg(REG_EPS, eps);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every expected result is in, then lets the pipeline drain fully.
  task automatic wait_drained();
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  // Sends one request. start_i is held high across back-to-back requests and only dropped
  // when a gap follows, so it never sees two assignments in one step.
  task automatic send_triangle(tri_req_t t, int unsigned gap);
    outcome_t o;
    start_i <= 1'b1;
    foreach (t.v[k]) vert_i[k] <= t.v[k];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    o.reason = classify_triangle(t);
    o.hit = (o.reason == RSN_HIT);
    pending_outcomes.push_back(o);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tri_req_t make_tri(int signed ax, int signed ay, int signed az,
                                        int signed bx, int signed by, int signed bz,
                                        int signed cx, int signed cy, int signed cz);
    tri_req_t t;
    t.v[0] = coord_t'(ax); t.v[1] = coord_t'(ay); t.v[2] = coord_t'(az);
    t.v[3] = coord_t'(bx); t.v[4] = coord_t'(by); t.v[5] = coord_t'(bz);
    t.v[6] = coord_t'(cx); t.v[7] = coord_t'(cy); t.v[8] = coord_t'(cz);
    return t;
  endfunction

  // A random triangle that is mostly placed around the ray, so that hits and all of the miss
  // reasons turn up; a fraction uses fully random coordinates to exercise every bit.
  function automatic tri_req_t random_tri();
    tri_req_t t;
    int signed span;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      foreach (t.v[k]) t.v[k] = coord_t'($urandom);
    end else begin
      span = (mode < 6) ? 1024 : 8192;
      foreach (t.v[k]) begin
        t.v[k] = coord_t'(int'(ray_org[k % 3]) + $signed($urandom_range(0, 2 * span)) - span);
      end
      if (mode == 9) begin
        // Degenerate: third vertex on the line of the first two.
        foreach (t.v[k]) if (k >= 6) t.v[k] = t.v[k - 6];
      end
    end
    return t;
  endfunction

  // Directed rows. The reset ray looks down +z from the origin with direction 1.0.
  // The base triangle below spans x, y in [-1, 1] at z = 1.0, so it is hit.
  tri_row_t directed_rows[$];

  task automatic build_directed();
    tri_row_t r;
    r.fixed = 1'b0;
    // Plain hit, in front of the origin.
    r.tri_in = make_tri(256, -256, 256, -256, -256, 256, -256, 256, 256);
    directed_rows.push_back(r);
    // Triangle behind the origin.
    r.tri_in = make_tri(256, -256, -256, -256, -256, -256, -256, 256, -256);
    directed_rows.push_back(r);
    // Reversed winding, so the determinant is positive.
    r.tri_in = make_tri(-256, 256, 256, -256, -256, 256, 256, -256, 256);
    directed_rows.push_back(r);
    // u outside: triangle shifted off in x.
    r.tri_in = make_tri(1024, 0, 256, 512, 0, 256, 512, 256, 256); directed_rows.push_back(r);
    // v outside: triangle shifted off in y.
    r.tri_in = make_tri(256, -512, 256, -256, -512, 256, -256, -256, 256);
    directed_rows.push_back(r);
    // Edge boundaries: the ray passes exactly through a vertex and along an edge.
    r.tri_in = make_tri(256, 0, 256, 0, 0, 256, 0, 256, 256); directed_rows.push_back(r);
    r.tri_in = make_tri(0, 0, 256, -256, 0, 256, -256, 256, 256); directed_rows.push_back(r);
    r.tri_in = make_tri(256, -256, 256, 0, 0, 256, -256, 256, 256); directed_rows.push_back(r);
    // Touching at t == 0: the triangle lies in the plane of the origin.
    r.tri_in = make_tri(256, -256, 0, -256, -256, 0, -256, 256, 0); directed_rows.push_back(r);
    // Coordinate extremes, valid but huge.
    r.tri_in = make_tri(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, 32767);
    directed_rows.push_back(r);
    r.tri_in = make_tri(32767, -32768, -32768, -32768, -32768, -32768, -32768, 32767, -32768);
    directed_rows.push_back(r);
    // Fixed outcomes read off directly: every degenerate triangle is parallel.
    r.fixed = 1'b1;
    r.reason = RSN_PARALLEL;
    r.tri_in = make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0); directed_rows.push_back(r);
    r.tri_in = make_tri(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767);
    directed_rows.push_back(r);
    // A triangle parallel to the ray (lies in the x-z plane).
    r.tri_in = make_tri(256, 0, 256, -256, 0, 256, 0, 0, 512); directed_rows.push_back(r);
    r.tri_in = make_tri(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    directed_rows.push_back(r);
  endtask

  task automatic run_directed();
    outcome_t o;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].fixed) begin
        o.reason = classify_triangle(directed_rows[i].tri_in);
        if (o.reason != directed_rows[i].reason)
          report_mismatch("predictor on fixed row", o.reason, directed_rows[i].reason);
      end
      send_triangle(directed_rows[i].tri_in, (i % 3 == 0) ? 1 : 0);
    end
    start_i <= 1'b0;
    wait_drained();
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_triangle(random_tri(), ($urandom_range(0, 3) == 0) ? 0 : pick_gap());
      // Now and then the sender holds off until every outstanding result is back.
      if ($urandom_range(0, 199) == 0) begin
        start_i <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk_i);
      end
    end
    start_i <= 1'b0;
    wait_drained();
  endtask

  initial begin
    ray_org = '{default: '0};
    ray_dir = '{0, 0, coord_t'(1 << CF)};
    ray_eps = 32'd1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset ray first, then the directed table.
    build_directed();
    run_directed();

    // A few hundred random triangles under each ray setting, extremes included.
    run_random(RANDOM_TRIS / 6);
    load_ray(0, 0, 0, 0, 0, 256, 32'd0);
    run_directed();
    run_random(RANDOM_TRIS / 6);
    load_ray(-32768, 32767, -32768, 32767, -32768, 32767, 32'hFFFF_FFFF);
    run_random(RANDOM_TRIS / 6);
    load_ray(32767, -32768, 32767, -32768, 32767, -32768, 32'h0000_0001);
    run_random(RANDOM_TRIS / 6);
    load_ray(coord_t'(300), coord_t'(-700), coord_t'(-1500), coord_t'(45), coord_t'(-90),
             coord_t'(256), 32'h0100_0000);
    run_random(RANDOM_TRIS / 6);
    load_ray(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom_range(0, 512) - 256), coord_t'($urandom_range(0, 512) - 256),
             coord_t'(-256), $urandom);
    run_random(RANDOM_TRIS / 6);

    repeat (PIPE_DEPTH * 4) @(posedge clk_i);
    $display("checked %0d results, %0d hits; parallel %0d, u out %0d, v out %0d, behind %0d",
             checked_count, hit_count, reason_seen[RSN_PARALLEL], reason_seen[RSN_U_OUT],
             reason_seen[RSN_V_OUT], reason_seen[RSN_BEHIND]);
    $display("six ray settings, register extremes and random triangles with random gaps");
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (pending_outcomes.size() != 0)
        $display("%0d expected results never arrived", pending_outcomes.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
